// ----- rtl/core/accel_offset_calibrate_defines.svh -----
// Assertion macros shared by the offset calibration RTL.
`ifndef ACCEL_OFFSET_CALIBRATE_DEFINES_SVH
`define ACCEL_OFFSET_CALIBRATE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle in reset.
`define AOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle in reset.
`define AOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/aoc_pkg.sv -----
// Types and constants of the accelerometer offset calibration block.
`default_nettype none

package aoc_pkg;

  // Field widths
  localparam int unsigned DataW   = 16;
  localparam int unsigned OneGW   = 15;
  localparam int unsigned TiltW   = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned NumAxes = 3;

  // Axis slots
  localparam int unsigned AxRoll  = 0;
  localparam int unsigned AxPitch = 1;
  localparam int unsigned AxVert  = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_ONE_G = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_TILT  = 1'b1;

  // Mounting rotation codes
  localparam logic [TiltW-1:0] TILT_NONE  = 2'd0;
  localparam logic [TiltW-1:0] TILT_LEFT  = 2'd1;
  localparam logic [TiltW-1:0] TILT_RIGHT = 2'd2;

  // Reset value of one_g
  localparam logic [OneGW-1:0] ONE_G_RST = 15'd265;

  // Rotation datapath: sum of two axes, its magnitude times 7, then / 10
  localparam int unsigned RotW   = DataW + 1;
  localparam int unsigned MagW   = 19;
  localparam int unsigned RecipW = 20;
  localparam int unsigned ProdW  = MagW + RecipW;
  localparam int unsigned RecipShift = 23;
  // ceil(2^23 / 10); exact for magnitudes below 2^22
  localparam logic [RecipW-1:0] RECIP_TEN = 20'd838861;

endpackage

`default_nettype wire

// ----- rtl/core/aoc_intf.sv -----
// Stream and configuration channel interfaces of the offset calibration block.
`default_nettype none

interface aoc_sample_if;
  import aoc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DataW-1:0]  sample_roll;
  logic signed [DataW-1:0]  sample_pitch;
  logic signed [DataW-1:0]  sample_vert;

  modport source (output valid, output sample_roll, output sample_pitch,
                  output sample_vert, input ready);
  modport sink   (input valid, input sample_roll, input sample_pitch,
                  input sample_vert, output ready);
endinterface

interface aoc_result_if;
  import aoc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DataW-1:0]  out_roll;
  logic signed [DataW-1:0]  out_pitch;
  logic signed [DataW-1:0]  out_vert;
  logic                     calibrating;

  modport source (output valid, output out_roll, output out_pitch,
                  output out_vert, output calibrating, input ready);
  modport sink   (input valid, input out_roll, input out_pitch,
                  input out_vert, input calibrating, output ready);
endinterface

interface aoc_cfg_if;
  import aoc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [OneGW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/accel_offset_calibrate.sv -----
// Top level: accelerometer offset calibration with optional 45-degree rotation.
`default_nettype none

// Six-register pipeline that takes one three-axis beat per clock and returns
// one result beat per input beat, in order. Each result is registered through
// the stages below and then held on result_o until result_o.ready takes it.
// Stages: input register; running-sum and offset update; offset subtract;
// roll/pitch sum for rotation; magnitude times 7; multiply by the reciprocal
// of 10 into the output register. A stall on the result side propagates back
// through the stage valids, so sample_i.ready drops only once every stage is
// full and result_o.ready is low. The first 2^CAL_SHIFT samples after reset
// (512 by default) are calibration samples: they update the per-axis offsets,
// the last one also removes one_g from the vertical offset, and their results
// carry calibrating = 1. Offsets then stay fixed until reset. Write one_g and
// tilt_mode only while no beat is in flight.
module accel_offset_calibrate #(
  parameter int unsigned CAL_SHIFT = 9
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  aoc_cfg_if.sink       cfg_i,
  aoc_sample_if.sink    sample_i,
  aoc_result_if.source  result_o
);
  import aoc_pkg::*;
  `include "accel_offset_calibrate_defines.svh"

  localparam int unsigned SumW = DataW + CAL_SHIFT;
  localparam int unsigned CntW = CAL_SHIFT + 1;
  localparam logic [CntW-1:0] CAL_INIT = CntW'(1) << CAL_SHIFT;
  localparam logic [CntW-1:0] CAL_LAST = CntW'(1);

  // Configuration registers
  logic [OneGW-1:0] one_g_q;
  logic [TiltW-1:0] tilt_q;

  // Calibration state
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [SumW-1:0]  sum_q [NumAxes];
  logic signed [DataW-1:0] off_q [NumAxes];
  logic signed [SumW-1:0]  sum_d [NumAxes];
  logic signed [DataW-1:0] off_d [NumAxes];
  logic signed [SumW-1:0]  sum_new [NumAxes];
  logic signed [DataW-1:0] off_new [NumAxes];

  // Stage registers
  logic                    s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic signed [DataW-1:0] s1_smp_q [NumAxes];
  logic                    s1_cal_q, s1_first_q, s1_last_q;
  logic signed [DataW-1:0] s2_smp_q [NumAxes];
  logic signed [DataW-1:0] s2_off_q [NumAxes];
  logic                    s2_cal_q;
  logic signed [DataW-1:0] s3_c_q [NumAxes];
  logic                    s3_cal_q, s3_rot_q, s3_left_q;
  logic signed [RotW-1:0]  s4_sr_q, s4_sp_q;
  logic signed [DataW-1:0] s4_c_q [NumAxes];
  logic                    s4_cal_q, s4_rot_q;
  logic [MagW-1:0]         s5_mr_q, s5_mp_q;
  logic                    s5_nr_q, s5_np_q;
  logic signed [DataW-1:0] s5_c_q [NumAxes];
  logic                    s5_cal_q, s5_rot_q;
  logic signed [DataW-1:0] out_q [NumAxes];
  logic                    out_cal_q;

  // Stage load enables
  logic go1, go2, go3, go4, go5, go6;
  logic in_acc;
  logic upd;

  // Combinational stage results
  logic signed [DataW-1:0] c_d [NumAxes];
  logic signed [RotW-1:0]  r_ext, p_ext, sr_d, sp_d;
  logic [RotW-1:0]         ar_d, ap_d;
  logic [RotW+2:0]         mr7_d, mp7_d;
  logic [ProdW-1:0]        pr_d, pp_d;
  logic [DataW-1:0]        qr_d, qp_d;
  logic [DataW-1:0]        one_g_ext;

  // Advance a stage when it is empty or the next one advances
  assign go6 = !out_v_q || result_o.ready;
  assign go5 = !s5_v_q || go6;
  assign go4 = !s4_v_q || go5;
  assign go3 = !s3_v_q || go4;
  assign go2 = !s2_v_q || go3;
  assign go1 = !s1_v_q || go2;

  assign sample_i.ready = go1;
  assign in_acc = sample_i.valid && go1;
  assign upd    = s1_v_q && go2 && s1_cal_q;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_g_q <= ONE_G_RST;
      tilt_q  <= TILT_NONE;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ONE_G: one_g_q <= cfg_i.data;
        REG_TILT:  tilt_q  <= cfg_i.data[TiltW-1:0];
        default: ;
      endcase
    end
  end

  // Count down the calibration samples at acceptance
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && (cnt_q != '0)) begin
      cnt_d = cnt_q - CAL_LAST;
    end
  end

  // Running sums and offsets for the beat leaving the input register
  assign one_g_ext = {1'b0, one_g_q};

  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      sum_new[a] = (s1_first_q ? '0 : sum_q[a]) + SumW'(s1_smp_q[a]);
      off_new[a] = DataW'(sum_new[a] >>> CAL_SHIFT);
    end
    if (s1_last_q) begin
      off_new[AxVert] = DataW'(sum_new[AxVert] >>> CAL_SHIFT) - one_g_ext;
    end
    for (int a = 0; a < NumAxes; a++) begin
      sum_d[a] = s1_cal_q ? sum_new[a] : sum_q[a];
      off_d[a] = s1_cal_q ? off_new[a] : off_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CAL_INIT;
      for (int a = 0; a < NumAxes; a++) begin
        sum_q[a] <= '0;
        off_q[a] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
      if (upd) begin
        for (int a = 0; a < NumAxes; a++) begin
          sum_q[a] <= sum_d[a];
          off_q[a] <= off_d[a];
        end
      end
    end
  end

  // Subtract offsets, wrapping to 16 bits
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      c_d[a] = s2_smp_q[a] - s2_off_q[a];
    end
  end

  // Roll/pitch sums for the selected rotation
  always_comb begin
    r_ext = RotW'(s3_c_q[AxRoll]);
    p_ext = RotW'(s3_c_q[AxPitch]);
    sr_d  = s3_left_q ? (r_ext + p_ext) : (r_ext - p_ext);
    sp_d  = s3_left_q ? (p_ext - r_ext) : (p_ext + r_ext);
  end

  // Magnitude times 7
  always_comb begin
    ar_d  = s4_sr_q[RotW-1] ? RotW'(-s4_sr_q) : RotW'(s4_sr_q);
    ap_d  = s4_sp_q[RotW-1] ? RotW'(-s4_sp_q) : RotW'(s4_sp_q);
    mr7_d = {ar_d, 3'b000} - {3'b000, ar_d};
    mp7_d = {ap_d, 3'b000} - {3'b000, ap_d};
  end

  // Divide by 10 through the reciprocal; the sign is restored at the output register
  always_comb begin
    pr_d = ProdW'(s5_mr_q) * ProdW'(RECIP_TEN);
    pp_d = ProdW'(s5_mp_q) * ProdW'(RECIP_TEN);
    qr_d = pr_d[RecipShift +: DataW];
    qp_d = pp_d[RecipShift +: DataW];
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (go1) s1_v_q  <= sample_i.valid;
      if (go2) s2_v_q  <= s1_v_q;
      if (go3) s3_v_q  <= s2_v_q;
      if (go4) s4_v_q  <= s3_v_q;
      if (go5) s5_v_q  <= s4_v_q;
      if (go6) out_v_q <= s5_v_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_smp_q[AxRoll]  <= sample_i.sample_roll;
      s1_smp_q[AxPitch] <= sample_i.sample_pitch;
      s1_smp_q[AxVert]  <= sample_i.sample_vert;
      s1_cal_q          <= (cnt_q != '0);
      s1_first_q        <= (cnt_q == CAL_INIT);
      s1_last_q         <= (cnt_q == CAL_LAST);
    end
    if (go2 && s1_v_q) begin
      s2_smp_q <= s1_smp_q;
      s2_off_q <= off_d;
      s2_cal_q <= s1_cal_q;
    end
    if (go3 && s2_v_q) begin
      s3_c_q    <= c_d;
      s3_cal_q  <= s2_cal_q;
      s3_rot_q  <= (tilt_q == TILT_LEFT) || (tilt_q == TILT_RIGHT);
      s3_left_q <= (tilt_q == TILT_LEFT);
    end
    if (go4 && s3_v_q) begin
      s4_sr_q  <= sr_d;
      s4_sp_q  <= sp_d;
      s4_c_q   <= s3_c_q;
      s4_cal_q <= s3_cal_q;
      s4_rot_q <= s3_rot_q;
    end
    if (go5 && s4_v_q) begin
      s5_mr_q  <= mr7_d[MagW-1:0];
      s5_mp_q  <= mp7_d[MagW-1:0];
      s5_nr_q  <= s4_sr_q[RotW-1];
      s5_np_q  <= s4_sp_q[RotW-1];
      s5_c_q   <= s4_c_q;
      s5_cal_q <= s4_cal_q;
      s5_rot_q <= s4_rot_q;
    end
    if (go6 && s5_v_q) begin
      out_q[AxVert] <= s5_c_q[AxVert];
      if (s5_rot_q) begin
        out_q[AxRoll]  <= s5_nr_q ? -qr_d : qr_d;
        out_q[AxPitch] <= s5_np_q ? -qp_d : qp_d;
      end else begin
        out_q[AxRoll]  <= s5_c_q[AxRoll];
        out_q[AxPitch] <= s5_c_q[AxPitch];
      end
      out_cal_q <= s5_cal_q;
    end
  end

  // Drive the result channel
  assign result_o.valid       = out_v_q;
  assign result_o.out_roll    = out_q[AxRoll];
  assign result_o.out_pitch   = out_q[AxPitch];
  assign result_o.out_vert    = out_q[AxVert];
  assign result_o.calibrating = out_cal_q;

  // Checks
  `AOC_ASSERT_NEXT(a_cnt_step, in_acc && (cnt_q != '0),
                   cnt_q == $past(cnt_q) - 1'b1, "calibration count did not step")
  `AOC_ASSERT_NEXT(a_cnt_done, cnt_q == '0, cnt_q == '0, "calibration count left zero")
  `AOC_ASSERT_NEXT(a_off_hold, (cnt_q == '0) && !(s1_v_q && s1_cal_q),
                   $stable(off_q[AxVert]), "offset moved after calibration")
  `AOC_ASSERT_NOW(a_ready_free, !out_v_q, sample_i.ready,
                  "input stalled with empty output stage")

endmodule

`default_nettype wire
